### src/pcfa_pkg.sv
// Shared types and constants for the page color frame allocator.
package pcfa_pkg;

	localparam int PAGE_W  = 36;
	localparam int MAP_W   = 64;
	localparam int COLOR_W = 6;
	localparam int NCOL_W  = 7;
	localparam int FRAME_W = 55;
	localparam int STAT_W  = 3;

	localparam int MAX_COLOR_COUNT = 64;

	localparam logic [1:0] ADDR_COLOR_COUNT = 2'd0;

	localparam logic [STAT_W-1:0] ST_SAME     = 3'd0;
	localparam logic [STAT_W-1:0] ST_FALLBACK = 3'd1;
	localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_ADDED    = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

	localparam logic [NCOL_W-1:0] NCOL_RESET = 7'd32;

	typedef struct packed {
		logic              operation;
		logic [PAGE_W-1:0] page_number;
		logic [MAP_W-1:0]  map_entry;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [PAGE_W-1:0]  dest_page;
		logic [COLOR_W-1:0] page_color;
		logic [COLOR_W-1:0] dest_color;
		logic               dest_valid;
		logic               color_from_frame;
		logic               same_color;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_LOOK, S_ADD, S_POP_SAME, S_SCAN, S_POP_SCAN, S_READ, S_WAIT,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture item, start modulo
		logic mod_step;  // one remainder bit
		logic write;     // push page
		logic pop_same;  // pop own color
		logic scan_init;
		logic scan_step;
		logic pop_scan;  // pop scanned color
		logic drop;
		logic full;
		logic emit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mod_done;
		logic own_full;
		logic own_empty;
		logic scan_hit;
		logic scan_end;
	} dp_stat_t;

endpackage

### src/pcfa_datapath.sv
// Datapath: serial modulo, stack heights, slot memory and result register.
module pcfa_datapath import pcfa_pkg::*; #(
	parameter int SLOTS_PER_COLOR = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  in_item_t          item,
	input  logic [NCOL_W-1:0] color_count,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	output out_item_t         result
);
	localparam int CI_W  = (MAX_COLOR_COUNT > 1) ? $clog2(MAX_COLOR_COUNT) : 1;
	localparam int SI_W  = (SLOTS_PER_COLOR > 1) ? $clog2(SLOTS_PER_COLOR) : 1;
	localparam int H_W   = $clog2(SLOTS_PER_COLOR + 1);
	localparam int NC_W  = $clog2(MAX_COLOR_COUNT + 1);
	localparam int A_W   = CI_W + SI_W;
	localparam int DEPTH = 1 << A_W;
	localparam int DV_W  = (NC_W > NCOL_W) ? NC_W : NCOL_W;
	localparam int RW    = DV_W + 1;
	localparam logic [H_W-1:0]  SLOTS  = H_W'(SLOTS_PER_COLOR);
	localparam logic [DV_W-1:0] MAXC   = DV_W'(MAX_COLOR_COUNT);
	localparam logic [5:0]      LASTB  = 6'(FRAME_W - 1);

	// heights live in a small memory; a set flag marks a nonempty stack
	logic [H_W-1:0]    hmem [MAX_COLOR_COUNT];
	logic [H_W-1:0]    hrd_q;
	logic [MAX_COLOR_COUNT-1:0] nonempty_q;
	logic [PAGE_W-1:0] mem [DEPTH];
	logic [PAGE_W-1:0] rd_q;

	logic [PAGE_W-1:0]  page_q;
	logic               from_frame_q;
	logic [FRAME_W-1:0] dividend_q;
	logic [DV_W-1:0]    divisor_q;
	logic [DV_W-1:0]    rem_q;
	logic [5:0]         bit_q;
	logic               mod_done_q;
	logic [CI_W-1:0]    scan_q;
	logic [DV_W-1:0]    scan_cnt_q;
	logic               scan_mode_q;
	out_item_t          res_q;

	logic [FRAME_W-1:0] frame;
	logic               ff;
	logic [DV_W-1:0]    ncl, nact;
	logic [RW-1:0]      trial;
	logic [CI_W-1:0]    own;
	logic [CI_W-1:0]    hraddr;
	logic [H_W-1:0]     own_h, scan_h;

	assign frame = item.map_entry[FRAME_W-1:0];
	assign ff = item.map_entry[63] && !item.map_entry[62] && (frame != '0);
	assign ncl = DV_W'(color_count);
	always_comb begin
		nact = ncl;
		if (nact == '0) nact = DV_W'(1);
		if (nact > MAXC) nact = MAXC;
	end
	assign trial = {rem_q, dividend_q[FRAME_W-1]};
	assign own    = CI_W'(rem_q);
	// own color is read while the modulo settles, the scanned color while scanning
	assign hraddr = scan_mode_q ? scan_q : own;
	assign own_h  = nonempty_q[own] ? hrd_q : '0;
	assign scan_h = hrd_q;

	assign stat.mod_done  = mod_done_q;
	assign stat.own_full  = own_h >= SLOTS;
	assign stat.own_empty = !nonempty_q[own];
	assign stat.scan_hit  = nonempty_q[scan_q];
	assign stat.scan_end  = scan_cnt_q >= divisor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
			mod_done_q <= 1'b0;
		end else begin
			if (cmd.load) mod_done_q <= 1'b0;
			else if (cmd.mod_step && bit_q == '0) mod_done_q <= 1'b1;
			if (cmd.write) nonempty_q[own] <= 1'b1;
			if (cmd.pop_same) nonempty_q[own] <= (own_h != H_W'(1));
			if (cmd.pop_scan) nonempty_q[scan_q] <= (scan_h != H_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) hmem[own] <= own_h + 1'b1;
		if (cmd.pop_same) hmem[own] <= own_h - 1'b1;
		if (cmd.pop_scan) hmem[scan_q] <= scan_h - 1'b1;
		hrd_q <= hmem[hraddr];
	end

	// restoring remainder, one dividend bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q       <= item.page_number;
			from_frame_q <= ff;
			dividend_q   <= ff ? frame : FRAME_W'(item.page_number);
			divisor_q    <= nact;
			rem_q        <= '0;
			bit_q        <= LASTB;
		end else if (cmd.mod_step) begin
			if (trial >= {1'b0, divisor_q}) rem_q <= DV_W'(trial - {1'b0, divisor_q});
			else rem_q <= DV_W'(trial);
			dividend_q <= dividend_q << 1;
			bit_q      <= bit_q - 1'b1;
		end
		if (cmd.scan_init) begin
			scan_q     <= '0;
			scan_cnt_q <= '0;
		end else if (cmd.scan_step) begin
			scan_q     <= scan_q + 1'b1;
			scan_cnt_q <= scan_cnt_q + 1'b1;
		end
		if (cmd.load) scan_mode_q <= 1'b0;
		else if (cmd.scan_init) scan_mode_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.write) mem[{own, SI_W'(own_h)}] <= page_q;
		if (cmd.pop_same) rd_q <= mem[{own, SI_W'(own_h - 1'b1)}];
		else if (cmd.pop_scan) rd_q <= mem[{scan_q, SI_W'(scan_h - 1'b1)}];
	end

	always_ff @(posedge clk) begin
		if (cmd.write || cmd.full || cmd.drop) begin
			res_q.status     <= cmd.write ? ST_ADDED : (cmd.full ? ST_FULL : ST_DROPPED);
			res_q.dest_page  <= '0;
			res_q.dest_color <= '0;
			res_q.dest_valid <= 1'b0;
			res_q.same_color <= 1'b0;
		end
		if (cmd.pop_same) begin
			res_q.status      <= ST_SAME;
			res_q.dest_color  <= COLOR_W'(own);
			res_q.dest_valid  <= 1'b1;
			res_q.same_color  <= 1'b1;
		end
		if (cmd.pop_scan) begin
			res_q.status      <= ST_FALLBACK;
			res_q.dest_color  <= COLOR_W'(scan_q);
			res_q.dest_valid  <= 1'b1;
			res_q.same_color  <= (scan_q == own);
		end
		if (cmd.emit && res_q.dest_valid) res_q.dest_page <= rd_q;
		if (cmd.load) begin
			res_q.dest_valid <= 1'b0;
		end
		res_q.page_color       <= COLOR_W'(rem_q);
		res_q.color_from_frame <= from_frame_q;
	end

	always_comb begin
		result = res_q;
		if (res_q.dest_valid) result.dest_page = rd_q;
	end
endmodule

### src/pcfa_ctrl.sv
// Controller state machine sequencing modulo, push, pop and fallback scan.
module pcfa_ctrl import pcfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     operation,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     done
);
	state_t state_q, state_d;
	logic   op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) op_q <= operation;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: if (start) begin
				cmd.load = 1'b1;
				state_d  = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_done) begin
					cmd.mod_step = 1'b0;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (!op_q) begin
					if (stat.own_full) cmd.full = 1'b1;
					else cmd.write = 1'b1;
					state_d = S_WAIT;
				end else if (!stat.own_empty) begin
					cmd.pop_same = 1'b1;
					state_d = S_READ;
				end else begin
					cmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_end) begin
					cmd.drop = 1'b1;
					state_d = S_WAIT;
				end else if (stat.scan_hit) begin
					// height of the hit color is read during this cycle
					state_d = S_POP_SCAN;
				end else cmd.scan_step = 1'b1;
			end
			S_POP_SCAN: begin
				cmd.pop_scan = 1'b1;
				state_d = S_READ;
			end
			S_READ: state_d = S_WAIT;
			S_WAIT: state_d = S_DONE;
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### src/page_color_frame_allocator.sv
// Top level: APB register, controller and datapath of the page color allocator.
// Every item first runs the bit-serial modulo of its frame or page number. A fallback
// place then scans the colors from index zero up to the one it pops from, and a dropped
// place scans the whole color count without a hit.
// The result is shown for one cycle with done high and must be taken then; busy is
// high from acceptance until that cycle ends.
module page_color_frame_allocator import pcfa_pkg::*; #(
	parameter int SLOTS_PER_COLOR = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    in_item,
	output logic        done,
	output out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [NCOL_W-1:0] ncol_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy_c;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ncol_q <= NCOL_RESET;
		else if (psel && penable && pwrite && paddr == ADDR_COLOR_COUNT)
			ncol_q <= pwdata[NCOL_W-1:0];
	end
	assign prdata = (paddr == ADDR_COLOR_COUNT) ? 32'(ncol_q) : '0;

	pcfa_ctrl u_ctrl (
		.clk, .arst_n, .start, .operation(in_item.operation),
		.stat, .cmd, .busy(busy_c), .done
	);
	assign busy = busy_c;

	pcfa_datapath #(
		.SLOTS_PER_COLOR(SLOTS_PER_COLOR)
	) u_dp (
		.clk, .arst_n, .item(in_item), .color_count(ncol_q),
		.cmd, .stat, .result(out_item)
	);
endmodule
